/* hw/rtl/vt4_pkg.sv */
package vt4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COMP_W        = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_REGS      = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int PIPE_DEPTH    = 5;

    localparam logic CMD_FULL  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic  cmd;
        comp_t in_x;
        comp_t in_y;
        comp_t in_z;
        comp_t in_w;
    } vt4_req_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        comp_t out_w;
    } vt4_rsp_t;

endpackage

/* hw/rtl/vt4_row_dot.sv */
module vt4_row_dot #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  vt4_pkg::comp_t [3:0]  vec,
    input  vt4_pkg::comp_t [3:0]  coef,
    output vt4_pkg::comp_t        result
);

    localparam int PROD_W = 2 * vt4_pkg::COMP_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [vt4_pkg::COMP_W-1:0] SAT_MAX =
        {1'b0, {(vt4_pkg::COMP_W-1){1'b1}}};
    localparam logic signed [vt4_pkg::COMP_W-1:0] SAT_MIN =
        {1'b1, {(vt4_pkg::COMP_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-vt4_pkg::COMP_W:0] upper;
    vt4_pkg::comp_t           result_next;
    vt4_pkg::comp_t           result_reg;

    // products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i] <= $signed(vec[i]) * $signed(coef[i]);
        end
    end

    // pair sums
    always_ff @(posedge clk)
    begin
        pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
    end

    // full sum with rounding half
    always_ff @(posedge clk)
    begin
        sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + ROUND_HALF;
    end

    // shift down and saturate
    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        upper   = shifted[SUM_W-1:vt4_pkg::COMP_W-1];
        if ((upper == '0) || (upper == '1))
        begin
            result_next = shifted[vt4_pkg::COMP_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            result_next = SAT_MIN;
        end
        else
        begin
            result_next = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* hw/rtl/vertex_transform_4x4.sv */
// vertex_transform_4x4: signed fixed-point 4x4 matrix times 4-vector
// request channel: an item is taken at a clock edge with start high and busy
//   low; busy stays low, so one request may be issued every cycle
// cmd selects a full vector or a point (w taken as 1.0, out_w given as zero)
// result channel: done is high for one cycle with the result on rsp; the
//   result passes the input register, multiply, pair add, sum and round
//   and saturate registers and is on rsp while done is high, one result
//   per request
// throughput: one vector per cycle, set by the 16 parallel multipliers and
//   the fully pipelined adder tree behind them
// config channel: cfg_ready stays high; cfg_index 0..7 selects a matrix
//   register (row r, columns 2h and 2h+1 at index 2r+h, low half first),
//   other indexes are dropped; write only while no request is in flight
// reset clears the pipeline valid bits and loads the identity matrix
// the receiver cannot stall: results are presented once and not held
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  vt4_pkg::vt4_req_t              req,
    output logic                           done,
    output vt4_pkg::vt4_rsp_t              rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vt4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vt4_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW = vt4_pkg::COMP_W;
    localparam int DEPTH = vt4_pkg::PIPE_DEPTH;
    localparam logic [vt4_pkg::CFG_W-1:0] ONE_LO = vt4_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [vt4_pkg::CFG_W-1:0] ONE_HI = ONE_LO << CW;
    localparam logic [CW-1:0] ONE_COMP = CW'(1) << FRAC_BITS;

    logic [vt4_pkg::CFG_W-1:0] mat_reg [vt4_pkg::CFG_REGS];
    vt4_pkg::vt4_req_t         in_reg;
    logic [DEPTH-1:0]          valid_reg;
    logic [DEPTH-1:0]          valid_next;
    logic [DEPTH-1:0]          cmd_reg;
    logic                      accept;
    vt4_pkg::comp_t [3:0]      vec;
    vt4_pkg::comp_t [3:0]      row_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt4_pkg::CFG_REGS; i++)
            begin
                mat_reg[i] <= '0;
            end
            mat_reg[0] <= ONE_LO;
            mat_reg[2] <= ONE_HI;
            mat_reg[5] <= ONE_LO;
            mat_reg[7] <= ONE_HI;
        end
        else if (cfg_valid && cfg_ready &&
                 (cfg_index < vt4_pkg::CFG_IDX_W'(vt4_pkg::CFG_REGS)))
        begin
            mat_reg[cfg_index[$clog2(vt4_pkg::CFG_REGS)-1:0]] <= cfg_data;
        end
    end

    // valid bits travel alongside the data
    assign valid_next = {valid_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req;
        end
        cmd_reg <= {cmd_reg[DEPTH-2:0], req.cmd};
    end

    assign vec[0] = in_reg.in_x;
    assign vec[1] = in_reg.in_y;
    assign vec[2] = in_reg.in_z;
    assign vec[3] = (in_reg.cmd == vt4_pkg::CMD_POINT) ? ONE_COMP : in_reg.in_w;

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        vt4_pkg::comp_t [3:0] coef;

        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign coef[c] = mat_reg[2*r + c/2][(c%2)*CW +: CW];
        end

        vt4_row_dot #(
            .FRAC_BITS (FRAC_BITS)
        ) u_row (
            .clk    (clk),
            .vec    (vec),
            .coef   (coef),
            .result (row_out[r])
        );
    end

    assign done      = valid_reg[DEPTH-1];
    assign rsp.out_x = row_out[0];
    assign rsp.out_y = row_out[1];
    assign rsp.out_z = row_out[2];
    assign rsp.out_w = (cmd_reg[DEPTH-1] == vt4_pkg::CMD_POINT) ? '0 : row_out[3];

endmodule

/* hw/rtl/vt4_checker.sv */
module vt4_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  vt4_pkg::vt4_req_t              req,
    input  logic                           done,
    input  vt4_pkg::vt4_rsp_t              rsp,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready
);

    // every result comes from an earlier accepted request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, vt4_pkg::PIPE_DEPTH))
        else $error("result without matching request");

    // point requests give a zero w result
    a_point_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && (req.cmd == vt4_pkg::CMD_POINT),
                       vt4_pkg::PIPE_DEPTH)) |-> (rsp.out_w == '0))
        else $error("point request gave nonzero w");

    // pipeline never pushes back on requests
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

/* tb/vertex_transform_4x4_tb.sv */
`timescale 1ns / 1ps

module vertex_transform_4x4_tb;

    import vt4_pkg::*;

    localparam int    WATCHDOG_LIMIT = 3000;
    localparam comp_t COMP_MAX       = 32'sh7fff_ffff;
    localparam comp_t COMP_MIN       = 32'sh8000_0000;
    localparam comp_t FIX_ONE        = 32'sd1 <<< FRAC_BITS_DEF;
    localparam comp_t FIX_HALF       = 32'sd1 <<< (FRAC_BITS_DEF - 1);

    localparam logic signed [71:0] ROUND_HALF = 72'sd1 <<< (FRAC_BITS_DEF - 1);
    localparam logic signed [71:0] SUM_MAX    = 72'sd2147483647;
    localparam logic signed [71:0] SUM_MIN    = -72'sd2147483648;

    typedef enum int {
        MAT_IDENT,
        MAT_LSB,
        MAT_MAX,
        MAT_MIN,
        MAT_ZERO,
        MAT_SMALL,
        MAT_FULL,
        MAT_MIXED
    } mat_style_e;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    vt4_req_t             req       = '0;
    logic                 done;
    vt4_rsp_t             rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic [CFG_W-1:0] mat_regs [CFG_REGS];
    vt4_req_t         pending_vectors [$];
    vt4_rsp_t         expected_rsp [$];

    int  gap_left        = 0;
    bit  no_gaps         = 1'b0;
    int  vectors_pushed  = 0;
    int  vectors_sent    = 0;
    int  points_sent     = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    int  matrix_settings = 1;
    int  stall_cycles    = 0;
    int  errors          = 0;

    vertex_transform_4x4 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic vt4_rsp_t transform_vertex(input vt4_req_t r);
        comp_t                v [4];
        comp_t                res [4];
        comp_t                entry;
        logic signed [71:0]   acc;
        logic signed [71:0]   q;
        vt4_rsp_t             o;
        int                   row;
        int                   col;
        v[0] = r.in_x;
        v[1] = r.in_y;
        v[2] = r.in_z;
        v[3] = (r.cmd == CMD_POINT) ? FIX_ONE : r.in_w;
        for (row = 0; row < 4; row++)
        begin
            acc = '0;
            for (col = 0; col < 4; col++)
            begin
                entry = mat_regs[2 * row + col / 2][32 * (col % 2) +: 32];
                acc = acc + entry * v[col];
            end
            acc = acc + ROUND_HALF;
            q = acc >>> FRAC_BITS_DEF;
            if (q > SUM_MAX)
                res[row] = COMP_MAX;
            else if (q < SUM_MIN)
                res[row] = COMP_MIN;
            else
                res[row] = q[31:0];
        end
        o.out_x = res[0];
        o.out_y = res[1];
        o.out_z = res[2];
        o.out_w = (r.cmd == CMD_POINT) ? '0 : res[3];
        return o;
    endfunction

    function automatic logic [CFG_W-1:0] identity_reg(input int idx);
        case (idx)
            0, 5:    return {32'h0, FIX_ONE};
            2, 7:    return {FIX_ONE, 32'h0};
            default: return '0;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (no_gaps || sel < 50)
            return 0;
        else if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return COMP_MAX;
                    1:       return COMP_MIN;
                    2:       return '0;
                    3:       return FIX_ONE;
                    4:       return -FIX_ONE;
                    default: return $urandom_range(0, 1) ? FIX_HALF : -FIX_HALF;
                endcase
            end
            1, 2, 3, 4: return comp_t'($urandom);
            default:    return comp_t'(int'($urandom_range(0, 32'h20_0000)) - 32'h10_0000);
        endcase
    endfunction

    function automatic comp_t mat_entry(input mat_style_e style);
        case (style)
            MAT_LSB:   return 32'sd1;
            MAT_MAX:   return COMP_MAX;
            MAT_MIN:   return COMP_MIN;
            MAT_ZERO:  return '0;
            MAT_SMALL: return comp_t'(int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000);
            MAT_FULL:  return comp_t'($urandom);
            default:   return rand_comp();
        endcase
    endfunction

    function automatic vt4_req_t make_vector(input logic cmd, input comp_t x, input comp_t y,
                                             input comp_t z, input comp_t w);
        vt4_req_t r;
        r.cmd  = cmd;
        r.in_x = x;
        r.in_y = y;
        r.in_z = z;
        r.in_w = w;
        return r;
    endfunction

    function automatic vt4_req_t rand_vector();
        logic cmd;
        cmd = ($urandom_range(0, 1) == 1) ? CMD_POINT : CMD_FULL;
        return make_vector(cmd, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    function automatic mat_style_e phase_style(input int p);
        case (p % 12)
            0:       return MAT_SMALL;
            1:       return MAT_FULL;
            2:       return MAT_MIXED;
            3:       return MAT_SMALL;
            4:       return MAT_IDENT;
            5:       return MAT_FULL;
            6:       return MAT_MIXED;
            7:       return MAT_ZERO;
            8:       return MAT_SMALL;
            9:       return MAT_MAX;
            10:      return MAT_MIN;
            default: return MAT_FULL;
        endcase
    endfunction

    task automatic push_vector(input vt4_req_t r);
        pending_vectors.push_back(r);
        vectors_pushed++;
    endtask

    // called at a clock edge, returns at the edge that takes the write or after a random idle gap with cfg_valid low
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_REGS)
            mat_regs[idx] = val;
        cfg_writes++;
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic load_matrix(input mat_style_e style);
        int i;
        for (i = 0; i < CFG_REGS; i++)
        begin
            if (style == MAT_IDENT)
                cfg_write(CFG_IDX_W'(i), identity_reg(i));
            else
                cfg_write(CFG_IDX_W'(i), {mat_entry(style), mat_entry(style)});
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_REGS, 15)), {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        matrix_settings++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (results_checked < vectors_pushed)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic check_field(input string name, input comp_t want, input comp_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            req      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsp.push_back(transform_vertex(req));
                vectors_sent++;
                if (req.cmd == CMD_POINT)
                    points_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_vectors.size() > 0)
                begin
                    start    <= 1'b1;
                    req      <= pending_vectors.pop_front();
                    gap_left <= pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        vt4_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result with no request in flight: %h", rsp);
                    errors++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("out_x", want.out_x, rsp.out_x);
                    check_field("out_y", want.out_y, rsp.out_y);
                    check_field("out_z", want.out_z, rsp.out_z);
                    check_field("out_w", want.out_w, rsp.out_w);
                    results_checked++;
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int p;
        int n;
        for (i = 0; i < CFG_REGS; i++)
            mat_regs[i] = identity_reg(i);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset: field extremes, point mode ignores w
        push_vector(make_vector(CMD_FULL, '0, '0, '0, '0));
        push_vector(make_vector(CMD_FULL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
        push_vector(make_vector(CMD_FULL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
        push_vector(make_vector(CMD_POINT, FIX_ONE, -FIX_ONE, COMP_MAX, 32'sh1234_5678));
        push_vector(make_vector(CMD_POINT, '0, '0, '0, COMP_MIN));
        push_vector(make_vector(CMD_FULL, 32'sd1, -32'sd1, FIX_HALF, -FIX_HALF));
        wait_drained();

        // one-lsb matrix: rounding ties go up, dropped register indexes
        cfg_write(4'd8, {$urandom, $urandom});
        cfg_write(4'd15, {$urandom, $urandom});
        load_matrix(MAT_LSB);
        push_vector(make_vector(CMD_FULL, FIX_HALF, '0, '0, '0));
        push_vector(make_vector(CMD_FULL, -FIX_HALF, '0, '0, '0));
        push_vector(make_vector(CMD_FULL, FIX_HALF - 1, '0, '0, '0));
        push_vector(make_vector(CMD_FULL, -FIX_HALF - 1, '0, '0, '0));
        push_vector(make_vector(CMD_POINT, FIX_HALF >>> 1, FIX_HALF >>> 1, '0, COMP_MAX));
        wait_drained();

        // saturation at both ends
        load_matrix(MAT_MAX);
        push_vector(make_vector(CMD_FULL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
        push_vector(make_vector(CMD_FULL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
        push_vector(make_vector(CMD_POINT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MIN));
        push_vector(make_vector(CMD_FULL, COMP_MAX, COMP_MIN, '0, '0));
        wait_drained();

        load_matrix(MAT_MIN);
        push_vector(make_vector(CMD_FULL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
        push_vector(make_vector(CMD_FULL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
        push_vector(make_vector(CMD_FULL, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
        wait_drained();

        for (p = 0; p < 12; p++)
        begin
            load_matrix(phase_style(p));
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(140, 175);
            for (i = 0; i < n; i++)
                push_vector(rand_vector());
            wait_drained();
        end

        $display("sent %0d vectors (%0d in point mode) under %0d matrix settings",
                 vectors_sent, points_sent, matrix_settings);
        $display("%0d register writes, %0d results checked, %0d errors",
                 cfg_writes, results_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
